@@ hdl/dat_lzss_block_decoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros used by dlzss_ctrl
// ----------------------------------------------------------------------------
`ifndef DAT_LZSS_BLOCK_DECODER_CORE_MACROS_SVH
`define DAT_LZSS_BLOCK_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define DLZSS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlzss: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define DLZSS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlzss: next-cycle check failed");

`else

`define DLZSS_ASSERT_IMP(label, clk, rst, ante, cons)
`define DLZSS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/dlzss_pkg.sv @@
// ----------------------------------------------------------------------------
// dlzss_pkg
// types and constants of the lzss block decoder
// ----------------------------------------------------------------------------
package dlzss_pkg;

  localparam int WIN_BYTES = 4096;
  localparam int WIN_AW    = $clog2(WIN_BYTES);

  // write position at the start of every lzss block
  localparam logic [WIN_AW-1:0] WIN_START = WIN_AW'(WIN_BYTES - 18);
  localparam logic [7:0]        SPACE     = 8'h20;
  localparam logic [3:0]        FLAG_COUNT = 4'd8;
  localparam logic [4:0]        MATCH_MIN  = 5'd3;

  // end cause codes
  localparam logic [1:0] END_INPUT  = 2'd0;
  localparam logic [1:0] END_HEADER = 2'd1;
  localparam logic [1:0] END_LIMIT  = 2'd2;

  typedef enum logic [4:0] {
    PH_HDR_HI   = 5'b00001,
    PH_HDR_LO   = 5'b00010,
    PH_RAW      = 5'b00100,
    PH_LZ       = 5'b01000,
    PH_MATCH_HI = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    S_PARSE = 2'b01,
    S_MATCH = 2'b10
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
    logic [1:0] end_cause;
    logic       truncated;
  } res_t;

  typedef struct packed {
    logic              clear;
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
  } win_cmd_t;

endpackage

@@ hdl/dlzss_if.sv @@
// ----------------------------------------------------------------------------
// dlzss stream interfaces
// compressed input word channel and decoded output word channel
// ----------------------------------------------------------------------------
interface dlzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface dlzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       stream_end;
  logic [1:0] end_cause;
  logic       truncated;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output stream_end, output end_cause, output truncated, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input stream_end, input end_cause, input truncated, output ready);
endinterface

@@ hdl/dlzss_window.sv @@
// ----------------------------------------------------------------------------
// dlzss_window
// 4096-byte history memory with fill tracking and write-to-read forwarding
// ----------------------------------------------------------------------------
module dlzss_window (
  input  logic                clk,
  input  logic                rst,
  input  dlzss_pkg::win_cmd_t cmd,
  output logic [7:0]          rdata
);

  logic [7:0]                   mem [dlzss_pkg::WIN_BYTES];
  logic [7:0]                   mem_q;
  logic [dlzss_pkg::WIN_AW-1:0] raddr_q;
  logic                         fwd_hit;
  logic [7:0]                   fwd_data;
  // entries written since the block start, saturating at the window size
  logic [dlzss_pkg::WIN_AW:0]   fill;
  logic [dlzss_pkg::WIN_AW-1:0] arc_ofs;
  logic                         written;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      mem_q    <= mem[cmd.raddr];
      raddr_q  <= cmd.raddr;
      fwd_data <= cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      fwd_hit <= 1'b0;
    end else begin
      if (cmd.clear) begin
        fill <= '0;
      end else if (cmd.we && !fill[dlzss_pkg::WIN_AW]) begin
        fill <= fill + 1'b1;
      end
      if (cmd.re) begin
        fwd_hit <= cmd.we && (cmd.waddr == cmd.raddr);
      end
    end
  end

  // writes run upward from the block start, so written entries form one arc
  assign arc_ofs = raddr_q - dlzss_pkg::WIN_START;
  assign written = fill[dlzss_pkg::WIN_AW] || ({1'b0, arc_ofs} < fill);

  always_comb begin
    if (fwd_hit) begin
      rdata = fwd_data;
    end else if (written) begin
      rdata = mem_q;
    end else begin
      rdata = dlzss_pkg::SPACE;
    end
  end

endmodule

@@ hdl/dlzss_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlzss_ctrl
// header and token parser with the match copy sequencer
// ----------------------------------------------------------------------------
`include "dat_lzss_block_decoder_core_macros.svh"

module dlzss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                in_ready,
  input  logic [31:0]         output_limit,
  input  logic                can_push,
  output logic                push,
  output dlzss_pkg::res_t     res,
  output dlzss_pkg::win_cmd_t win,
  input  logic [7:0]          win_rdata
);

  dlzss_pkg::state_t            state, state_next;
  dlzss_pkg::phase_t            phase, phase_next;
  logic [7:0]                   header_high, header_high_next;
  logic [15:0]                  bytes_left, bytes_left_next;
  logic [7:0]                   flags, flags_next;
  logic [3:0]                   flags_left, flags_left_next;
  logic [7:0]                   offset_low, offset_low_next;
  logic [31:0]                  bytes_emitted, bytes_emitted_next;
  logic                         finished, finished_next;
  logic [dlzss_pkg::WIN_AW-1:0] wp, wp_next;
  logic [dlzss_pkg::WIN_AW-1:0] rp, rp_next;
  logic [4:0]                   m_rem, m_rem_next;
  logic                         m_last, m_last_next;
  logic                         m_trunc, m_trunc_next;

  logic                         in_fire;
  logic [15:0]                  left_dec;
  logic [31:0]                  be_inc;
  logic                         hit;
  logic [15:0]                  hdr;
  logic [dlzss_pkg::WIN_AW-1:0] match_rp;
  logic                         emit;
  logic                         fin;
  logic [1:0]                   cause;
  logic                         trunc;
  logic                         start;
  logic                         mdone;

  always_comb begin
    state_next         = state;
    phase_next         = phase;
    header_high_next   = header_high;
    bytes_left_next    = bytes_left;
    flags_next         = flags;
    flags_left_next    = flags_left;
    offset_low_next    = offset_low;
    bytes_emitted_next = bytes_emitted;
    finished_next      = finished;
    wp_next            = wp;
    rp_next            = rp;
    m_rem_next         = m_rem;
    m_last_next        = m_last;
    m_trunc_next       = m_trunc;
    push               = 1'b0;
    res                = '0;
    win                = '0;
    emit               = 1'b0;
    fin                = 1'b0;
    cause              = dlzss_pkg::END_INPUT;
    trunc              = 1'b0;
    start              = 1'b0;
    mdone              = 1'b0;

    // words that arrive after the end are swallowed
    in_ready = finished || ((state == dlzss_pkg::S_PARSE) && can_push);
    in_fire  = in_valid && in_ready;
    left_dec = (bytes_left != 16'd0) ? bytes_left - 16'd1 : bytes_left;
    be_inc   = bytes_emitted + 32'd1;
    hit      = be_inc >= output_limit;
    hdr      = {header_high, in_byte};
    match_rp = {in_byte[7:4], offset_low};

    unique case (state)
      dlzss_pkg::S_PARSE: begin
        if (in_fire && !finished) begin
          if (output_limit == 32'd0) begin
            // stored member
            emit               = 1'b1;
            bytes_emitted_next = be_inc;
            fin                = in_last;
          end else if (bytes_emitted >= output_limit) begin
            fin   = 1'b1;
            cause = dlzss_pkg::END_LIMIT;
          end else begin
            unique case (phase)
              dlzss_pkg::PH_HDR_HI: begin
                header_high_next = in_byte;
                phase_next       = dlzss_pkg::PH_HDR_LO;
              end
              dlzss_pkg::PH_HDR_LO: begin
                if (hdr == 16'd0) begin
                  phase_next = dlzss_pkg::PH_HDR_HI;
                  fin        = 1'b1;
                  cause      = dlzss_pkg::END_HEADER;
                end else if (hdr[15]) begin
                  bytes_left_next = (~hdr) + 16'd1;
                  phase_next      = dlzss_pkg::PH_RAW;
                end else begin
                  bytes_left_next = hdr;
                  win.clear       = 1'b1;
                  wp_next         = dlzss_pkg::WIN_START;
                  flags_next      = 8'd0;
                  flags_left_next = 4'd0;
                  phase_next      = dlzss_pkg::PH_LZ;
                end
              end
              dlzss_pkg::PH_RAW: begin
                bytes_left_next = left_dec;
                emit            = 1'b1;
                if (left_dec == 16'd0) begin
                  phase_next = dlzss_pkg::PH_HDR_HI;
                end
              end
              dlzss_pkg::PH_LZ: begin
                bytes_left_next = left_dec;
                if (flags_left == 4'd0) begin
                  flags_next      = in_byte;
                  flags_left_next = dlzss_pkg::FLAG_COUNT;
                  if (left_dec == 16'd0) begin
                    phase_next = dlzss_pkg::PH_HDR_HI;
                  end
                end else begin
                  flags_next      = flags >> 1;
                  flags_left_next = flags_left - 4'd1;
                  if (flags[0]) begin
                    win.we    = 1'b1;
                    win.waddr = wp;
                    win.wdata = in_byte;
                    wp_next   = wp + 1'b1;
                    emit      = 1'b1;
                    if (left_dec == 16'd0) begin
                      phase_next = dlzss_pkg::PH_HDR_HI;
                    end
                  end else begin
                    // second match byte is taken even past the block end
                    offset_low_next = in_byte;
                    phase_next      = dlzss_pkg::PH_MATCH_HI;
                  end
                end
              end
              dlzss_pkg::PH_MATCH_HI: begin
                bytes_left_next = left_dec;
                start           = 1'b1;
                win.re          = 1'b1;
                win.raddr       = match_rp;
                rp_next         = match_rp + 1'b1;
                m_rem_next      = {1'b0, in_byte[3:0]} + dlzss_pkg::MATCH_MIN;
                m_last_next     = in_last;
                m_trunc_next    = left_dec != 16'd0;
                phase_next      = (left_dec == 16'd0) ? dlzss_pkg::PH_HDR_HI
                                                      : dlzss_pkg::PH_LZ;
                state_next      = dlzss_pkg::S_MATCH;
              end
              default: begin
                phase_next = dlzss_pkg::PH_HDR_HI;
              end
            endcase
            if (emit) begin
              bytes_emitted_next = be_inc;
              if (hit) begin
                fin   = 1'b1;
                cause = dlzss_pkg::END_LIMIT;
              end
            end
            if (!fin && in_last && !start) begin
              fin   = 1'b1;
              cause = dlzss_pkg::END_INPUT;
              trunc = phase_next != dlzss_pkg::PH_HDR_HI;
            end
          end
          push           = emit || fin;
          res.out_byte   = emit ? in_byte : 8'd0;
          res.byte_valid = emit;
          res.run_last   = 1'b1;
          res.stream_end = fin;
          res.end_cause  = fin ? cause : dlzss_pkg::END_INPUT;
          res.truncated  = trunc;
          finished_next  = fin;
        end
      end
      dlzss_pkg::S_MATCH: begin
        if (can_push) begin
          win.we             = 1'b1;
          win.waddr          = wp;
          win.wdata          = win_rdata;
          wp_next            = wp + 1'b1;
          bytes_emitted_next = be_inc;
          mdone              = (m_rem == 5'd1) || hit;
          push               = 1'b1;
          res.out_byte       = win_rdata;
          res.byte_valid     = 1'b1;
          res.run_last       = mdone;
          if (hit) begin
            res.stream_end = 1'b1;
            res.end_cause  = dlzss_pkg::END_LIMIT;
            finished_next  = 1'b1;
          end else if (mdone && m_last) begin
            res.stream_end = 1'b1;
            res.end_cause  = dlzss_pkg::END_INPUT;
            res.truncated  = m_trunc;
            finished_next  = 1'b1;
          end
          if (mdone) begin
            state_next = dlzss_pkg::S_PARSE;
          end else begin
            // next read may hit the entry written this cycle
            win.re     = 1'b1;
            win.raddr  = rp;
            rp_next    = rp + 1'b1;
            m_rem_next = m_rem - 5'd1;
          end
        end
      end
      default: begin
        state_next = dlzss_pkg::S_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dlzss_pkg::S_PARSE;
      phase         <= dlzss_pkg::PH_HDR_HI;
      header_high   <= 8'd0;
      bytes_left    <= 16'd0;
      flags         <= 8'd0;
      flags_left    <= 4'd0;
      offset_low    <= 8'd0;
      bytes_emitted <= 32'd0;
      finished      <= 1'b0;
      wp            <= dlzss_pkg::WIN_START;
      rp            <= '0;
      m_rem         <= 5'd0;
      m_last        <= 1'b0;
      m_trunc       <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      header_high   <= header_high_next;
      bytes_left    <= bytes_left_next;
      flags         <= flags_next;
      flags_left    <= flags_left_next;
      offset_low    <= offset_low_next;
      bytes_emitted <= bytes_emitted_next;
      finished      <= finished_next;
      wp            <= wp_next;
      rp            <= rp_next;
      m_rem         <= m_rem_next;
      m_last        <= m_last_next;
      m_trunc       <= m_trunc_next;
    end
  end

  `DLZSS_ASSERT_IMP(a_push_room, clk, rst, push, can_push)
  `DLZSS_ASSERT_IMP(a_end_is_last, clk, rst, push && res.stream_end, res.run_last)
  `DLZSS_ASSERT_IMP(a_match_live, clk, rst, state == dlzss_pkg::S_MATCH, !finished)
  `DLZSS_ASSERT_NXT(a_quiet_after_end, clk, rst, push && res.stream_end, !push)

endmodule

@@ hdl/dat_lzss_block_decoder_core.sv @@
// ----------------------------------------------------------------------------
// dat_lzss_block_decoder_core
// lzss block decoder for one archive member, one compressed byte per word
//
// comp takes compressed words (in_byte, in_last); decomp gives decoded words
// with byte_valid, run_last, stream_end, end_cause and truncated. cfg_we with
// cfg_data sets the member's decoded size; the user must write it only while
// the block is idle, which the block does not enforce. Zero passes every byte
// through. A header, flag, raw or literal word's result shows in the output
// register in the cycle after acceptance. A match word issues the first
// history read in its accept cycle and then copies one byte per cycle while
// decomp takes them, holding comp meanwhile; each copied byte passes the
// history read and output registers. The history is cleared at each lzss
// block start by a fill count. Reset returns the parser to the first header
// and the byte count to zero; no clearing pass runs. When decomp stalls, the
// output register holds its word and the parser or the match copy waits;
// after the end of the stream, comp words are taken and dropped until reset.
// ----------------------------------------------------------------------------
module dat_lzss_block_decoder_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_data,
  dlzss_in_if.sink     comp,
  dlzss_out_if.source  decomp
);

  logic [31:0]         output_limit;
  logic                out_valid;
  dlzss_pkg::res_t     out_res;
  logic                can_push;
  logic                push;
  dlzss_pkg::res_t     res;
  dlzss_pkg::win_cmd_t win;
  logic [7:0]          win_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= 32'd0;
    end else if (cfg_we) begin
      output_limit <= cfg_data;
    end
  end

  assign can_push = !out_valid || decomp.ready;

  dlzss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (comp.valid),
    .in_byte      (comp.in_byte),
    .in_last      (comp.in_last),
    .in_ready     (comp.ready),
    .output_limit (output_limit),
    .can_push     (can_push),
    .push         (push),
    .res          (res),
    .win          (win),
    .win_rdata    (win_rdata)
  );

  dlzss_window u_window (
    .clk   (clk),
    .rst   (rst),
    .cmd   (win),
    .rdata (win_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (decomp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= res;
    end
  end

  assign decomp.valid      = out_valid;
  assign decomp.out_byte   = out_res.out_byte;
  assign decomp.byte_valid = out_res.byte_valid;
  assign decomp.run_last   = out_res.run_last;
  assign decomp.stream_end = out_res.stream_end;
  assign decomp.end_cause  = out_res.end_cause;
  assign decomp.truncated  = out_res.truncated;

endmodule

@@ tb/tb_dat_lzss_block_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dat_lzss_block_decoder_core
// self-checking bench for the lzss block decoder
//
// Feeds one member stream word by word: stored pass-through words, raw
// blocks, lzss blocks with literals and matches, and blocks with junk
// content. A scoreboard class decodes every accepted word itself and checks
// each decoded word in order. The size limit is rewritten while the block is
// idle. The run ends the stream one of several ways, chosen at random: input
// end inside a block or on a block edge, a zero header, the limit being
// reached, or the limit being lowered to or below the bytes already produced.
// ----------------------------------------------------------------------------
module tb_dat_lzss_block_decoder_core;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 200;
  localparam int DIRECTED_WORDS = 24;

  typedef enum {BLK_LZ, BLK_RAW, BLK_JUNK} blk_kind_t;
  typedef enum {CUT_NONE, CUT_END, CUT_MID} cut_t;
  typedef enum {TAIL_NONE, TAIL_FLAG, TAIL_MATCH} lz_tail_t;
  typedef enum {
    FIN_RAW_CUT, FIN_ZERO_HDR, FIN_LIMIT_HIT, FIN_LIMIT_LOW, FIN_BLOCK_END, FIN_MID_BLOCK
  } finish_t;

  // decodes the member stream and holds the decoded words still to come
  class dlzss_scoreboard;
    bit [7:0]            hist [dlzss_pkg::WIN_BYTES];
    bit [11:0]           wr_pos;
    bit [11:0]           rd_pos;
    dlzss_pkg::phase_t   phase;
    bit [7:0]            hdr_hi;
    bit [7:0]            flags;
    bit [7:0]            off_lo;
    bit [15:0]           blk_left;
    bit [3:0]            flags_left;
    bit [31:0]           emitted;
    bit [31:0]           limit;
    bit                  done;
    dlzss_pkg::res_t     step_q[$];
    dlzss_pkg::res_t     exp_q[$];
    int                  fails;
    int                  words_out;
    int                  lz_blocks;
    int                  raw_blocks;
    int                  match_cnt;

    function new();
      foreach (hist[i]) hist[i] = dlzss_pkg::SPACE;
      wr_pos = dlzss_pkg::WIN_START;
      phase = dlzss_pkg::PH_HDR_HI;
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function void push_word(bit [7:0] b, bit is_data);
      dlzss_pkg::res_t r;
      r = '0;
      r.out_byte = is_data ? b : 8'h00;
      r.byte_valid = is_data;
      step_q.push_back(r);
    endfunction

    // marks the last word of this step, adding a bare marker if there is none
    function void close_stream(bit [1:0] why, bit cut);
      dlzss_pkg::res_t r;
      if (step_q.size() == 0) push_word(8'h00, 1'b0);
      r = step_q.pop_back();
      r.stream_end = 1'b1;
      r.end_cause = why;
      r.truncated = cut;
      step_q.push_back(r);
      done = 1'b1;
    endfunction

    function void emit_byte(bit [7:0] b);
      if (done) return;
      push_word(b, 1'b1);
      emitted++;
      if (limit != 0 && emitted >= limit) close_stream(dlzss_pkg::END_LIMIT, 1'b0);
    endfunction

    function void put_hist(bit [7:0] b);
      hist[wr_pos] = b;
      wr_pos++;
    endfunction

    function void count_down();
      if (blk_left != 0) blk_left--;
    endfunction

    function void decode(bit [7:0] b);
      bit [15:0] h;
      bit [4:0]  len;
      bit [7:0]  v;
      bit        lit;
      case (phase)
        dlzss_pkg::PH_HDR_HI: begin
          hdr_hi = b;
          phase = dlzss_pkg::PH_HDR_LO;
        end
        dlzss_pkg::PH_HDR_LO: begin
          h = {hdr_hi, b};
          if (h == 16'h0000) begin
            phase = dlzss_pkg::PH_HDR_HI;
            close_stream(dlzss_pkg::END_HEADER, 1'b0);
          end else if (h[15]) begin
            blk_left = -h;
            phase = dlzss_pkg::PH_RAW;
            raw_blocks++;
          end else begin
            blk_left = h;
            foreach (hist[i]) hist[i] = dlzss_pkg::SPACE;
            wr_pos = dlzss_pkg::WIN_START;
            flags = '0;
            flags_left = '0;
            phase = dlzss_pkg::PH_LZ;
            lz_blocks++;
          end
        end
        dlzss_pkg::PH_RAW: begin
          count_down();
          emit_byte(b);
          if (blk_left == 0) phase = dlzss_pkg::PH_HDR_HI;
        end
        dlzss_pkg::PH_LZ: begin
          count_down();
          if (flags_left == 0) begin
            flags = b;
            flags_left = dlzss_pkg::FLAG_COUNT;
          end else begin
            lit = flags[0];
            flags >>= 1;
            flags_left--;
            if (lit) begin
              put_hist(b);
              emit_byte(b);
            end else begin
              off_lo = b;
              phase = dlzss_pkg::PH_MATCH_HI;
            end
          end
          // a match low byte on the last block byte still pulls in its high byte
          if (phase == dlzss_pkg::PH_LZ && blk_left == 0) phase = dlzss_pkg::PH_HDR_HI;
        end
        dlzss_pkg::PH_MATCH_HI: begin
          count_down();
          match_cnt++;
          rd_pos = {b[7:4], off_lo};
          len = {1'b0, b[3:0]} + dlzss_pkg::MATCH_MIN;
          for (int i = 0; i < len && !done; i++) begin
            v = hist[rd_pos];
            put_hist(v);
            rd_pos++;
            emit_byte(v);
          end
          phase = (blk_left == 0) ? dlzss_pkg::PH_HDR_HI : dlzss_pkg::PH_LZ;
        end
        default: phase = dlzss_pkg::PH_HDR_HI;
      endcase
    endfunction

    function void note_input(bit [7:0] b, bit last);
      dlzss_pkg::res_t r;
      step_q.delete();
      if (done) return;
      if (limit == 0) begin
        push_word(b, 1'b1);
        emitted++;
        if (last) close_stream(dlzss_pkg::END_INPUT, 1'b0);
      end else begin
        if (emitted >= limit) close_stream(dlzss_pkg::END_LIMIT, 1'b0);
        else decode(b);
        if (!done && last) close_stream(dlzss_pkg::END_INPUT, phase != dlzss_pkg::PH_HDR_HI);
      end
      if (step_q.size() != 0) begin
        r = step_q.pop_back();
        r.run_last = 1'b1;
        step_q.push_back(r);
      end
      foreach (step_q[i]) exp_q.push_back(step_q[i]);
    endfunction

    function void check_result(dlzss_pkg::res_t got);
      dlzss_pkg::res_t want;
      words_out++;
      if (exp_q.size() == 0) begin
        fails++;
        $display("%0t: word %0d expected none, actual byte=%02h bv=%0b last=%0b end=%0b",
                 $time, words_out, got.out_byte, got.byte_valid, got.run_last,
                 got.stream_end);
        $display("%0t: word %0d actual cause=%0d trunc=%0b",
                 $time, words_out, got.end_cause, got.truncated);
        return;
      end
      want = exp_q.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.run_last !== want.run_last || got.stream_end !== want.stream_end ||
          got.end_cause !== want.end_cause || got.truncated !== want.truncated) begin
        fails++;
        $display("%0t: word %0d expected byte=%02h bv=%0b last=%0b end=%0b cause=%0d trunc=%0b",
                 $time, words_out, want.out_byte, want.byte_valid, want.run_last,
                 want.stream_end, want.end_cause, want.truncated);
        $display("%0t: word %0d actual   byte=%02h bv=%0b last=%0b end=%0b cause=%0d trunc=%0b",
                 $time, words_out, got.out_byte, got.byte_valid, got.run_last,
                 got.stream_end, got.end_cause, got.truncated);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic [7:0]  body[$];
  bit          calm;
  int          words_sent;
  int          cfg_writes;
  int          cycles;
  dlzss_scoreboard sb;

  dlzss_in_if  comp_if();
  dlzss_out_if decomp_if();

  dat_lzss_block_decoder_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .comp(comp_if.sink),
    .decomp(decomp_if.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[dat_lzss_block_decoder_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    decomp_if.ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    if (!rst && decomp_if.valid && decomp_if.ready) begin
      sb.check_result(dlzss_pkg::res_t'({decomp_if.out_byte, decomp_if.byte_valid,
                                         decomp_if.run_last, decomp_if.stream_end,
                                         decomp_if.end_cause, decomp_if.truncated}));
    end
  end

  // valid stays up after a word is taken; the next call or an idle point drops it
  task automatic send_word(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      comp_if.valid <= 1'b0;
      @(negedge clk);
    end
    comp_if.valid <= 1'b1;
    comp_if.in_byte <= b;
    comp_if.in_last <= last;
    @(posedge clk);
    while (!comp_if.ready) @(posedge clk);
    sb.note_input(b, last);
    words_sent++;
  endtask

  task automatic send_hdr(input logic [15:0] h);
    send_word(h[15:8], 1'b0);
    send_word(h[7:0], 1'b0);
  endtask

  task automatic write_limit(input logic [31:0] value);
    @(negedge clk);
    comp_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // a header or flag word gives no word out but may still be in flight
    repeat (30) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.limit = value;
    cfg_writes++;
  endtask

  task automatic send_block(input blk_kind_t kind, input cut_t cut);
    logic [15:0] hdr;
    logic [11:0] off;
    logic [7:0]  flag;
    lz_tail_t    tail;
    int          n;
    int          pick;
    int          stop;
    body.delete();
    flag = '0;
    case (kind)
      BLK_RAW: begin
        n = $urandom_range(1, 8);
        repeat (n) body.push_back(8'($urandom));
        hdr = -16'(n);
      end
      BLK_JUNK: begin
        n = $urandom_range(1, 12);
        repeat (n) body.push_back(8'($urandom));
        hdr = 16'(n);
      end
      default: begin
        tail = lz_tail_t'($urandom_range(0, 2));
        n = (tail == TAIL_NONE) ? $urandom_range(1, 20) : 8 * $urandom_range(1, 2);
        for (int i = 0; i < n; i++) begin
          if (i % 8 == 0) begin
            flag = 8'($urandom);
            body.push_back(flag);
          end
          if (flag[i % 8]) begin
            pick = $urandom_range(0, 9);
            body.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
          end else begin
            // half the time near the fresh write area so copies carry real data
            case ($urandom_range(0, 3)) inside
              0, 1: off = dlzss_pkg::WIN_START + 12'($urandom_range(0, 40));
              2: off = 12'($urandom);
              default: off = 12'($urandom_range(0, 63));
            endcase
            body.push_back(off[7:0]);
            body.push_back({off[11:8], 4'($urandom)});
          end
        end
        hdr = 16'(body.size());
        if (tail == TAIL_FLAG) begin
          body.push_back(8'($urandom));
          hdr = 16'(body.size());
        end else if (tail == TAIL_MATCH) begin
          // the match high byte falls just past the block count
          body.push_back(8'($urandom) & 8'hFE);
          body.push_back(8'($urandom));
          body.push_back(8'($urandom));
          hdr = 16'(body.size() - 1);
        end
      end
    endcase
    send_hdr(hdr);
    stop = (cut == CUT_END) ? body.size() - 1 :
           (cut == CUT_MID) ? $urandom_range(0, body.size() - 1) : -1;
    foreach (body[i]) begin
      send_word(body[i], i == stop);
      if (i == stop) break;
    end
  endtask

  initial begin
    logic [7:0] lz_dir [7];
    finish_t    fin;
    blk_kind_t  kind;
    int         pick;
    int         detours;
    int         k;
    lz_dir = '{8'h03, 8'h00, 8'hFF, 8'hEE, 8'hFF, 8'h00, 8'h00};
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    comp_if.valid = 1'b0;
    comp_if.in_byte = '0;
    comp_if.in_last = 1'b0;
    decomp_if.ready = 1'b0;
    calm = 1'b0;
    detours = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stored member words go straight through with the reset limit of zero
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'hA5, 1'b0);
    write_limit(32'hFFFF_FFFF);
    send_hdr(16'hFFFF);
    send_word(8'hFF, 1'b0);
    // two literals, a longest overlapping match, a shortest match at offset zero
    send_hdr(16'h0007);
    foreach (lz_dir[i]) send_word(lz_dir[i], 1'b0);
    // match starting on the last block byte
    send_hdr(16'h0002);
    send_word(8'hFE, 1'b0);
    send_word(8'h34, 1'b0);
    send_word(8'h12, 1'b0);
    // block holding only a flag word
    send_hdr(16'h0001);
    send_word(8'h5A, 1'b0);

    while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
      calm = (words_sent >= 110 && words_sent < 190);
      if (detours < 2 && words_sent >= DIRECTED_WORDS + 90 * (detours + 1)) begin
        // short stored stretch in between blocks, then back to decoding
        write_limit(32'd0);
        repeat ($urandom_range(2, 5)) send_word(8'($urandom), 1'b0);
        write_limit(sb.emitted + $urandom_range(5000, 32'h7FFF_FFFF));
        detours++;
      end
      pick = $urandom_range(0, 99);
      kind = (pick < 65) ? BLK_LZ : (pick < 88) ? BLK_RAW : BLK_JUNK;
      send_block(kind, CUT_NONE);
    end
    calm = 1'b0;

    fin = finish_t'($urandom_range(0, 5));
    case (fin)
      FIN_RAW_CUT: begin
        send_hdr(16'h8000);
        k = $urandom_range(1, 6);
        for (int i = 1; i <= k; i++) send_word(8'($urandom), i == k);
      end
      FIN_ZERO_HDR: send_hdr(16'h0000);
      FIN_LIMIT_HIT: begin
        write_limit(sb.emitted + $urandom_range(1, 30));
        while (!sb.done) send_block($urandom_range(0, 2) != 0 ? BLK_LZ : BLK_RAW, CUT_NONE);
      end
      FIN_LIMIT_LOW: begin
        write_limit($urandom_range(1, sb.emitted));
        send_word(8'($urandom), 1'b0);
      end
      FIN_BLOCK_END: send_block(BLK_LZ, CUT_END);
      default: send_block(BLK_LZ, CUT_MID);
    endcase
    // words after the end are taken and dropped
    repeat (3) send_word(8'($urandom), 1'($urandom));
    @(negedge clk);
    comp_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d compressed words in, %0d decoded words out",
             words_sent, sb.words_out);
    $display("%0d lzss blocks, %0d raw, %0d matches, %0d limit writes, closed by %s",
             sb.lz_blocks, sb.raw_blocks, sb.match_cnt, cfg_writes, fin.name());
    if (sb.fails == 0) begin
      $display("[dat_lzss_block_decoder_core] OK");
    end else begin
      $display("[dat_lzss_block_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dlzss_pkg.sv
hdl/dlzss_if.sv
hdl/dlzss_window.sv
hdl/dlzss_ctrl.sv
hdl/dat_lzss_block_decoder_core.sv
tb/tb_dat_lzss_block_decoder_core.sv
